### src/mwcs_pkg.sv
// Package for the masked window contrast stretch: sizes, window and
// pipeline record types, and the constant level and bin lookup tables.
// No dependencies.
`timescale 1ns / 1ps

package mwcs_pkg;

    // Histogram bins in use (2..256) and derived sizes
    localparam int BINS    = 256;
    localparam int BIN_MAX = BINS - 1;
    localparam int BIN_W   = (BINS > 2) ? $clog2(BINS) : 1;

    localparam int PIX_W   = 8;
    localparam int MIDX_W  = 8;                 // index into the 256-bit mask
    localparam int MASK_W  = 256;
    localparam int WORD_W  = 64;
    localparam int CFG_IDX_W = 2;

    localparam int NUM_W   = 16;                // (p - lo) * 255
    localparam int REC_SH  = 16;                // reciprocal = 2^REC_SH / delta
    localparam int REC_W   = REC_SH + 1;
    localparam int PROD_W  = NUM_W + REC_W;
    localparam int QD_W    = NUM_W + PIX_W;
    localparam int DCNT_W  = 5;

    localparam int LVL_DIV = 2 * BIN_MAX;
    localparam int PIX_DIV = 510;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASK_WORD_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_WORD_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_WORD_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_WORD_3 = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEVEL,
        ST_DIV
    } t_win_state;

    // Window settings handed from the setup unit to the pixel pipeline
    typedef struct packed {
        logic              busy;
        logic              any;
        logic [PIX_W-1:0]  lo;
        logic [PIX_W-1:0]  hi;
        logic [PIX_W-1:0]  dlt;
        logic [REC_W-1:0]  recip;
    } t_window;

    // One pixel as it travels down the pipeline
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic              any;
        logic              ge_hi;
        logic              le_lo;
        logic              bin_on;
        logic [MIDX_W-1:0] idx;
        logic [PIX_W-1:0]  diff;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  q0;
        logic [QD_W-1:0]   qd;
    } t_item;

    typedef logic [BINS-1:0][PIX_W-1:0]        t_level_tab;
    typedef logic [MASK_W-1:0][MIDX_W-1:0]     t_bin_tab;

    // level = round(bin * 255 / (BINS-1)), half up
    function automatic t_level_tab gen_level_tab();
        t_level_tab t;
        int unsigned v;
        for (int i = 0; i < BINS; i++) begin
            v    = (i * 510 + BIN_MAX) / LVL_DIV;
            t[i] = PIX_W'(v);
        end
        return t;
    endfunction

    // bin = round(pixel * (BINS-1) / 255), half up
    function automatic t_bin_tab gen_bin_tab();
        t_bin_tab t;
        int unsigned v;
        for (int i = 0; i < MASK_W; i++) begin
            v    = (i * BIN_MAX * 2 + 255) / PIX_DIV;
            t[i] = MIDX_W'(v);
        end
        return t;
    endfunction

    localparam t_level_tab LEVEL_TAB = gen_level_tab();
    localparam t_bin_tab   BIN_TAB   = gen_bin_tab();

endpackage

### src/masked_window_contrast_stretch.sv
// Top level of the masked window contrast stretch: mask registers with
// window setup, and the pixel pipeline. Depends on mwcs_pkg, mwcs_window
// and mwcs_pipe.
//
//   channel   direction  handshake              payload
//   pixel in  input      i_valid / o_ready      i_pixel_in [7:0]
//   pixel out output     o_valid / i_ready      o_pixel_out [7:0]
//   config    input      i_cfg_we (no wait)     i_cfg_idx [1:0], i_cfg_data [63:0]
//
// One pixel per cycle unless setup runs or the output stalls; four pipeline stages and
// the output register, the multiply by the window reciprocal setting the cut.
// Each config write starts a window setup (bin scan, level lookup and, if a bin is
// set, a 17-step reciprocal divide); o_ready is low during it.
// Reset is synchronous, active low; it empties the pipe and the mask.
// A stalled output freezes every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps

module masked_window_contrast_stretch (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [mwcs_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mwcs_pkg::PIX_W-1:0]     o_pixel_out,
    input  logic                           i_cfg_we,
    input  logic [mwcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mwcs_pkg::WORD_W-1:0]    i_cfg_data
);

    mwcs_pkg::t_window               w_win;
    logic [mwcs_pkg::MIDX_W-1:0]     w_rd_idx;
    logic                            w_rd_bit;
    logic                            w_hold;

    // hold requests off while the window is rebuilt
    assign w_hold = w_win.busy || i_cfg_we;

    mwcs_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rd_idx   (w_rd_idx),
        .o_rd_bit   (w_rd_bit),
        .o_win      (w_win)
    );

    mwcs_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_hold),
        .i_win       (w_win),
        .o_rd_idx    (w_rd_idx),
        .i_rd_bit    (w_rd_bit),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out)
    );

`ifndef SYNTHESIS
    a_no_accept_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_win.busy && !i_cfg_we)
        else $error("request accepted during window setup");

    a_write_starts_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_win.busy)
        else $error("config write did not start window setup");

    a_window_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_win.busy && w_win.any) |-> (w_win.lo <= w_win.hi))
        else $error("window low level above high level");
`endif

endmodule

### src/mwcs_window.sv
// Mask registers and window setup: scans the mask for the lowest and
// highest set bins, maps them to levels and divides out the reciprocal.
// Depends on mwcs_pkg.
`timescale 1ns / 1ps

module mwcs_window (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mwcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mwcs_pkg::WORD_W-1:0]      i_cfg_data,
    input  logic [mwcs_pkg::MIDX_W-1:0]      i_rd_idx,
    output logic                             o_rd_bit,
    output mwcs_pkg::t_window                o_win
);

    localparam int CW  = mwcs_pkg::BIN_W;
    localparam int MW  = mwcs_pkg::MIDX_W;
    localparam int PW  = mwcs_pkg::PIX_W;
    localparam int RW  = mwcs_pkg::REC_W;
    localparam int DW  = mwcs_pkg::DCNT_W;

    logic [mwcs_pkg::WORD_W-1:0] r_mask_word_0, r_mask_word_1;
    logic [mwcs_pkg::WORD_W-1:0] r_mask_word_2, r_mask_word_3;
    logic [mwcs_pkg::MASK_W-1:0] w_mask;

    mwcs_pkg::t_win_state r_state, n_state;

    logic [CW-1:0] r_cnt, r_mn, r_mx;
    logic          r_any;
    logic [PW-1:0] r_lo, r_hi, r_dlt, r_rem;
    logic [RW-1:0] r_quo;
    logic [DW-1:0] r_dcnt;

    logic          w_busy, w_scan, w_level, w_div;
    logic [MW-1:0] w_idx;
    logic [PW:0]   w_rem_sh;
    logic          w_fit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_word_0 <= '0;
            r_mask_word_1 <= '0;
            r_mask_word_2 <= '0;
            r_mask_word_3 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mwcs_pkg::REG_MASK_WORD_0: r_mask_word_0 <= i_cfg_data;
                mwcs_pkg::REG_MASK_WORD_1: r_mask_word_1 <= i_cfg_data;
                mwcs_pkg::REG_MASK_WORD_2: r_mask_word_2 <= i_cfg_data;
                mwcs_pkg::REG_MASK_WORD_3: r_mask_word_3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_mask = {r_mask_word_3, r_mask_word_2, r_mask_word_1, r_mask_word_0};

    // One read port, shared: the scan owns it while setup runs
    assign w_idx    = w_busy ? MW'(r_cnt) : i_rd_idx;
    assign o_rd_bit = w_mask[w_idx];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mwcs_pkg::ST_IDLE:  n_state = mwcs_pkg::ST_IDLE;
            mwcs_pkg::ST_SCAN:  if (r_cnt == CW'(mwcs_pkg::BIN_MAX)) begin
                                    n_state = mwcs_pkg::ST_LEVEL;
                                end
            mwcs_pkg::ST_LEVEL: n_state = r_any ? mwcs_pkg::ST_DIV : mwcs_pkg::ST_IDLE;
            mwcs_pkg::ST_DIV:   if (r_dcnt == '0) begin
                                    n_state = mwcs_pkg::ST_IDLE;
                                end
            default:            n_state = mwcs_pkg::ST_IDLE;
        endcase
        // any write restarts the setup
        if (i_cfg_we) begin
            n_state = mwcs_pkg::ST_SCAN;
        end
    end

    // State decode
    always_comb begin
        w_busy  = 1'b1;
        w_scan  = 1'b0;
        w_level = 1'b0;
        w_div   = 1'b0;
        case (r_state)
            mwcs_pkg::ST_IDLE:  w_busy  = 1'b0;
            mwcs_pkg::ST_SCAN:  w_scan  = 1'b1;
            mwcs_pkg::ST_LEVEL: w_level = 1'b1;
            mwcs_pkg::ST_DIV:   w_div   = 1'b1;
            default:            w_busy  = 1'b1;
        endcase
    end

    // Restoring divide of 2^REC_SH by delta, one quotient bit a cycle
    assign w_rem_sh = {r_rem, r_dcnt == DW'(mwcs_pkg::REC_SH)};
    assign w_fit    = w_rem_sh >= {1'b0, r_dlt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwcs_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_any   <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cnt <= '0;
                r_any <= 1'b0;
            end else if (w_scan) begin
                r_cnt <= r_cnt + 1'b1;
                if (o_rd_bit) begin
                    r_any <= 1'b1;
                end
            end
            if (w_level) begin
                r_dcnt <= DW'(mwcs_pkg::REC_SH);
            end else if (w_div) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan && o_rd_bit) begin
            if (!r_any) begin
                r_mn <= r_cnt;
            end
            r_mx <= r_cnt;
        end
        if (w_level) begin
            r_lo  <= mwcs_pkg::LEVEL_TAB[r_mn];
            r_hi  <= mwcs_pkg::LEVEL_TAB[r_mx];
            r_dlt <= mwcs_pkg::LEVEL_TAB[r_mx] - mwcs_pkg::LEVEL_TAB[r_mn];
            r_rem <= '0;
            r_quo <= '0;
        end else if (w_div) begin
            r_rem <= w_fit ? PW'(w_rem_sh - {1'b0, r_dlt}) : PW'(w_rem_sh);
            r_quo <= {r_quo[RW-2:0], w_fit};
        end
    end

    assign o_win.busy  = w_busy;
    assign o_win.any   = r_any;
    assign o_win.lo    = r_lo;
    assign o_win.hi    = r_hi;
    assign o_win.dlt   = r_dlt;
    assign o_win.recip = r_quo;

endmodule

### src/mwcs_pipe.sv
// Pixel pipeline: compare against the window, look up the bin, scale by
// the reciprocal, correct the quotient and hold the result.
// Depends on mwcs_pkg.
`timescale 1ns / 1ps

module mwcs_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hold,
    input  mwcs_pkg::t_window             i_win,
    output logic [mwcs_pkg::MIDX_W-1:0]   o_rd_idx,
    input  logic                          i_rd_bit,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mwcs_pkg::PIX_W-1:0]    i_pixel_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mwcs_pkg::PIX_W-1:0]    o_pixel_out
);

    localparam int PW = mwcs_pkg::PIX_W;
    localparam int NW = mwcs_pkg::NUM_W;
    localparam int QW = mwcs_pkg::QD_W;

    mwcs_pkg::t_item r_s1, r_s2, r_s3, r_s4;
    logic            r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic [PW-1:0]   r_out_pixel;

    mwcs_pkg::t_item           n_s1, n_s2, n_s3, n_s4;
    logic [mwcs_pkg::PROD_W-1:0] w_prod;
    logic [QW-1:0]             w_rem;
    logic [NW-1:0]             w_q;
    logic [PW-1:0]             n_out_pixel;
    logic                      w_en;

    // Whole pipe advances unless the output register is stalled
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en && !i_hold;

    always_comb begin
        n_s1       = '0;
        n_s1.pix   = i_pixel_in;
        n_s1.any   = i_win.any;
        n_s1.ge_hi = i_pixel_in >= i_win.hi;
        n_s1.le_lo = i_pixel_in <= i_win.lo;
        n_s1.idx   = mwcs_pkg::BIN_TAB[i_pixel_in];
        n_s1.diff  = i_pixel_in - i_win.lo;
    end

    assign o_rd_idx = r_s1.idx;

    // num = diff * 255
    always_comb begin
        n_s2        = r_s1;
        n_s2.bin_on = i_rd_bit;
        n_s2.num    = {r_s1.diff, {PW{1'b0}}} - NW'(r_s1.diff);
    end

    // q0 = floor(num * recip / 2^REC_SH), at most one below the quotient
    assign w_prod = mwcs_pkg::PROD_W'(r_s2.num) * mwcs_pkg::PROD_W'(i_win.recip);
    always_comb begin
        n_s3    = r_s2;
        n_s3.q0 = w_prod[mwcs_pkg::REC_SH +: NW];
    end

    always_comb begin
        n_s4    = r_s3;
        n_s4.qd = QW'(r_s3.q0) * QW'(i_win.dlt);
    end

    // Correct the estimate and pick the result
    assign w_rem = QW'(r_s4.num) - r_s4.qd;
    assign w_q   = (w_rem >= QW'(i_win.dlt)) ? r_s4.q0 + 1'b1 : r_s4.q0;

    always_comb begin
        if (!r_s4.any) begin
            n_out_pixel = r_s4.pix;
        end else if (r_s4.ge_hi) begin
            n_out_pixel = '1;
        end else if (r_s4.le_lo || !r_s4.bin_on) begin
            n_out_pixel = '0;
        end else begin
            n_out_pixel = w_q[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= i_valid && !i_hold;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_s3        <= n_s3;
            r_s4        <= n_s4;
            r_out_pixel <= n_out_pixel;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pixel;

endmodule

### verif/tb_masked_window_contrast_stretch.sv
// Testbench for masked_window_contrast_stretch: directed and random pixel streams
// under several bin masks, checked against a behavioral window predictor.
// Depends on mwcs_pkg and the masked_window_contrast_stretch RTL.
`timescale 1ns / 1ps

module tb_masked_window_contrast_stretch;

    localparam int PIPE_LAT    = 5;
    localparam int STALL_LIMIT = 20000;
    localparam int MASKS_PER_PHASE = 10;
    localparam int PIX_PER_MASK    = 61;

    typedef enum int {
        MK_EMPTY,
        MK_FULL,
        MK_SINGLE,
        MK_WINDOW,
        MK_SPARSE,
        MK_DENSE
    } t_mask_kind;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [mwcs_pkg::PIX_W-1:0]     i_pixel_in;
    logic                           o_valid;
    logic                           i_ready;
    logic [mwcs_pkg::PIX_W-1:0]     o_pixel_out;
    logic                           i_cfg_we;
    logic [mwcs_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [mwcs_pkg::WORD_W-1:0]    i_cfg_data;

    logic [mwcs_pkg::MASK_W-1:0]    mask_mirror;
    logic [mwcs_pkg::PIX_W-1:0]     pix_expect[$];
    int                             err_cnt;
    int                             pixels_sent;
    int                             pixels_out;
    int                             mask_loads;
    int                             stall_cycles;
    int                             send_idle_pct;
    int                             recv_idle_pct;

    masked_window_contrast_stretch u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Lowest and highest set bin below BINS, scaled to byte levels
    function automatic void find_window(input logic [mwcs_pkg::MASK_W-1:0] m, output bit any,
                                        output int unsigned lo, output int unsigned hi);
        int unsigned d;
        int unsigned mn;
        int unsigned mx;
        d   = mwcs_pkg::BINS - 1;
        any = 1'b0;
        mn  = 0;
        mx  = 0;
        for (int b = 0; b < mwcs_pkg::BINS; b++) begin
            if (m[b]) begin
                if (!any) mn = b;
                mx  = b;
                any = 1'b1;
            end
        end
        lo = (mn * 510 + d) / (2 * d);
        hi = (mx * 510 + d) / (2 * d);
    endfunction

    function automatic logic [mwcs_pkg::PIX_W-1:0] stretch_pixel(
            input logic [mwcs_pkg::MASK_W-1:0] m, input logic [mwcs_pkg::PIX_W-1:0] p);
        bit          any;
        int unsigned lo;
        int unsigned hi;
        int unsigned d;
        int unsigned bin;
        int unsigned pv;
        d  = mwcs_pkg::BINS - 1;
        pv = p;
        find_window(m, any, lo, hi);
        if (!any) return p;
        if (pv >= hi) return 8'hFF;
        if (pv <= lo) return 8'h00;
        bin = (pv * d * 2 + 255) / 510;
        if (m[bin]) return 8'(((pv - lo) * 255) / (hi - lo));
        return 8'h00;
    endfunction

    // Requests in, results out, and the no-progress watchdog
    always @(posedge i_clk) begin
        logic [mwcs_pkg::PIX_W-1:0] want;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                pix_expect.push_back(stretch_pixel(mask_mirror, i_pixel_in));
            if (o_valid && i_ready) begin
                pixels_out++;
                if (pix_expect.size() == 0) begin
                    $error("pixel_out: unexpected result %0d", o_pixel_out);
                    err_cnt++;
                end else begin
                    want = pix_expect.pop_front();
                    if (o_pixel_out !== want) begin
                        $error("pixel_out mismatch: expected %0d, actual %0d", want,
                               o_pixel_out);
                        err_cnt++;
                    end
                end
            end
        end
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(input logic [mwcs_pkg::PIX_W-1:0] p);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Drop valid and hold until every pending pixel has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pix_expect.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [mwcs_pkg::CFG_IDX_W-1:0] idx,
                              input logic [mwcs_pkg::WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        mask_mirror[int'(idx) * mwcs_pkg::WORD_W +: mwcs_pkg::WORD_W] = data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_mask(input logic [mwcs_pkg::MASK_W-1:0] m);
        wait_drain();
        write_mask(mwcs_pkg::REG_MASK_WORD_0, m[63:0]);
        write_mask(mwcs_pkg::REG_MASK_WORD_1, m[127:64]);
        write_mask(mwcs_pkg::REG_MASK_WORD_2, m[191:128]);
        write_mask(mwcs_pkg::REG_MASK_WORD_3, m[255:192]);
        mask_loads++;
    endtask

    function automatic logic [mwcs_pkg::MASK_W-1:0] make_mask(input t_mask_kind kind);
        logic [mwcs_pkg::MASK_W-1:0] m;
        int                          mn;
        int                          mx;
        int                          span;
        int                          density;
        m = '0;
        case (kind)
            MK_EMPTY: m = '0;
            MK_FULL:  m = '1;
            MK_SINGLE: m[$urandom_range(mwcs_pkg::BINS - 1)] = 1'b1;
            MK_WINDOW: begin
                mn = $urandom_range(mwcs_pkg::BINS - 2);
                if ($urandom_range(1)) begin
                    mx = $urandom_range(mn + 1, mwcs_pkg::BINS - 1);
                end else begin
                    span = $urandom_range(1, 8);
                    mx   = (mn + span > mwcs_pkg::BINS - 1) ? mwcs_pkg::BINS - 1 : mn + span;
                end
                density = $urandom_range(100);
                m[mn] = 1'b1;
                m[mx] = 1'b1;
                for (int b = mn + 1; b < mx; b++) m[b] = ($urandom_range(99) < density);
            end
            // bits at or above BINS land here too and must be ignored
            MK_SPARSE: for (int b = 0; b < mwcs_pkg::MASK_W; b++) m[b] = ($urandom_range(99) < 3);
            default:   for (int w = 0; w < mwcs_pkg::MASK_W / 32; w++) m[w * 32 +: 32] = $urandom;
        endcase
        return m;
    endfunction

    task automatic test_empty_mask();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        send_pixel(8'h01);
    endtask

    task automatic test_full_window();
        load_mask('1);
        send_pixel(8'h00);
        send_pixel(8'h01);
        send_pixel(8'h7F);
        send_pixel(8'hFE);
        send_pixel(8'hFF);
    endtask

    // lo equals hi: every pixel saturates to one end
    task automatic test_single_bin();
        logic [mwcs_pkg::MASK_W-1:0] m;
        m = '0;
        m[100] = 1'b1;
        load_mask(m);
        send_pixel(8'd99);
        send_pixel(8'd100);
        send_pixel(8'd101);
        send_pixel(8'h00);
        send_pixel(8'hFF);
    endtask

    // Window with holes: unset bins inside the window give zero
    task automatic test_masked_holes();
        logic [mwcs_pkg::MASK_W-1:0] m;
        m = '0;
        m[10]  = 1'b1;
        m[250] = 1'b1;
        for (int b = 20; b <= 240; b += 2) m[b] = 1'b1;
        load_mask(m);
        send_pixel(8'd10);
        send_pixel(8'd11);
        send_pixel(8'd20);
        send_pixel(8'd21);
        send_pixel(8'd100);
        send_pixel(8'd249);
        send_pixel(8'd250);
    endtask

    task automatic test_random_stream(input int snd_pct, input int rcv_pct);
        logic [mwcs_pkg::MASK_W-1:0] m;
        bit                          any;
        int unsigned                 lo;
        int unsigned                 hi;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int k = 0; k < MASKS_PER_PHASE; k++) begin
            m = make_mask(t_mask_kind'(k % 6));
            load_mask(m);
            find_window(m, any, lo, hi);
            for (int n = 0; n < PIX_PER_MASK; n++) begin
                // hold the stream once until the pipe is empty
                if (k == 0 && n == PIX_PER_MASK / 2) wait_drain();
                if (any && $urandom_range(99) < 70)
                    send_pixel(8'($urandom_range(lo, hi)));
                else
                    send_pixel(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pixel_in    = '0;
        i_ready       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = mwcs_pkg::REG_MASK_WORD_0;
        i_cfg_data    = '0;
        mask_mirror   = '0;
        err_cnt       = 0;
        pixels_sent   = 0;
        pixels_out    = 0;
        mask_loads    = 0;
        stall_cycles  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_mask();
        test_full_window();
        test_single_bin();
        test_masked_holes();
        test_random_stream(14, 84);
        test_random_stream(84, 14);
        test_random_stream(0, 0);

        wait_drain();
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        $display("Covered %0d pixels in, %0d out, over %0d mask loads", pixels_sent,
                 pixels_out, mask_loads);
        $display("(empty, full, single-bin, holed window, sparse, dense; three stall mixes)");
        if (err_cnt == 0 && pix_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
